FILE: rtl/core/tcrq_pkg.sv
package tcrq_pkg;

  // Default store depth (sorted pending commands)
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  // Maximum commands released by one tick
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RESULTS + 1);
  // Depth of the front-to-back command queue
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // Field widths
  localparam int unsigned KEY_W = 5;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned MS_W = 32;
  localparam int unsigned US_W = 40;
  localparam int unsigned LETTER_W = 7;
  localparam int unsigned DIGIT_W = 6;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Status codes
  localparam logic STATUS_RELEASED = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // Character codes
  localparam logic [LETTER_W-1:0] CHAR_A = 7'd65;
  localparam logic [LETTER_W-1:0] CHAR_Z = 7'd90;
  localparam logic [DIGIT_W-1:0] CHAR_0 = 6'd48;
  localparam logic [KEY_W-1:0] KEY_LAST_LETTER = 5'd19;

  // Microsecond to millisecond rounding divider (radix 16)
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned HALF_MS = 500;
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DVD_W = 44;
  localparam int unsigned DIV_STEPS = DVD_W / DIV_RADIX_BITS;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);
  localparam int unsigned REM_W = 10;
  localparam logic [REM_W:0] MS_DIVISOR = (REM_W + 1)'(US_PER_MS);

  // Classified command travelling from front to back
  typedef struct packed {
    logic tick;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [MS_W-1:0] time_ms;
  } cmd_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_DONE
  } front_state_t;

  typedef enum logic {
    BS_IDLE,
    BS_RELEASE
  } back_state_t;

endpackage

FILE: rtl/core/tcrq_in_if.sv
interface tcrq_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [tcrq_pkg::KEY_W-1:0] cmd_key;
  logic [tcrq_pkg::VAL_W-1:0] cmd_value;
  logic [tcrq_pkg::MS_W-1:0] due_ms;
  logic [tcrq_pkg::US_W-1:0] elapsed_us;

  modport source (
    output valid, action, cmd_key, cmd_value, due_ms, elapsed_us,
    input ready
  );
  modport sink (
    input valid, action, cmd_key, cmd_value, due_ms, elapsed_us,
    output ready
  );
endinterface

FILE: rtl/core/tcrq_out_if.sv
interface tcrq_out_if;
  logic valid;
  logic ready;
  logic status;
  logic [tcrq_pkg::KEY_W-1:0] out_key;
  logic [tcrq_pkg::VAL_W-1:0] out_value;
  logic [tcrq_pkg::LETTER_W-1:0] code_letter;
  logic [tcrq_pkg::DIGIT_W-1:0] digit_hundreds;
  logic [tcrq_pkg::DIGIT_W-1:0] digit_tens;
  logic [tcrq_pkg::DIGIT_W-1:0] digit_ones;
  logic last;

  modport source (
    output valid, status, out_key, out_value, code_letter,
    output digit_hundreds, digit_tens, digit_ones, last,
    input ready
  );
  modport sink (
    input valid, status, out_key, out_value, code_letter,
    input digit_hundreds, digit_tens, digit_ones, last,
    output ready
  );
endinterface

FILE: rtl/core/tcrq_front.sv
module tcrq_front (
  input  logic                clk,
  input  logic                rst,
  tcrq_in_if.sink             req,
  output tcrq_pkg::cmd_t      push_data,
  output logic                push_valid,
  input  logic                push_full
);

  tcrq_pkg::front_state_t state, state_next;

  logic [tcrq_pkg::DVD_W-1:0] dvd;
  logic [tcrq_pkg::REM_W-1:0] rem;
  logic [tcrq_pkg::MS_W-1:0] quo;
  logic [tcrq_pkg::STEP_W-1:0] step;

  logic [tcrq_pkg::REM_W:0] r;
  logic [tcrq_pkg::DIV_RADIX_BITS-1:0] qbits;
  logic accept;
  logic start_div;

  // One radix-16 step of restoring division by 1000
  always_comb begin
    r = {1'b0, rem};
    qbits = '0;
    for (int b = 0; b < int'(tcrq_pkg::DIV_RADIX_BITS); b++) begin
      r = {r[tcrq_pkg::REM_W-1:0], dvd[tcrq_pkg::DVD_W-1-b]};
      qbits[tcrq_pkg::DIV_RADIX_BITS-1-b] = (r >= tcrq_pkg::MS_DIVISOR);
      if (qbits[tcrq_pkg::DIV_RADIX_BITS-1-b]) begin
        r = r - tcrq_pkg::MS_DIVISOR;
      end
    end
  end

  always_comb begin
    state_next = state;
    req.ready = 1'b0;
    push_valid = 1'b0;
    push_data.tick = tcrq_pkg::ACT_INSERT;
    push_data.key = req.cmd_key;
    push_data.value = req.cmd_value;
    push_data.time_ms = req.due_ms;
    start_div = 1'b0;
    case (state)
      tcrq_pkg::FS_IDLE: begin
        req.ready = !push_full;
        if (accept) begin
          if (req.action == tcrq_pkg::ACT_TICK) begin
            start_div = 1'b1;
            state_next = tcrq_pkg::FS_DIV;
          end else begin
            push_valid = 1'b1;
          end
        end
      end
      tcrq_pkg::FS_DIV: begin
        if (step == tcrq_pkg::STEP_W'(tcrq_pkg::DIV_STEPS - 1)) begin
          state_next = tcrq_pkg::FS_DONE;
        end
      end
      tcrq_pkg::FS_DONE: begin
        push_valid = 1'b1;
        push_data.tick = tcrq_pkg::ACT_TICK;
        push_data.time_ms = quo;
        if (!push_full) begin
          state_next = tcrq_pkg::FS_IDLE;
        end
      end
      default: begin
        state_next = tcrq_pkg::FS_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcrq_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath: add half a millisecond, then divide
  always_ff @(posedge clk) begin
    if (start_div) begin
      dvd <= tcrq_pkg::DVD_W'(req.elapsed_us) + tcrq_pkg::DVD_W'(tcrq_pkg::HALF_MS);
      rem <= '0;
      quo <= '0;
      step <= '0;
    end else if (state == tcrq_pkg::FS_DIV) begin
      dvd <= dvd << tcrq_pkg::DIV_RADIX_BITS;
      rem <= r[tcrq_pkg::REM_W-1:0];
      quo <= {quo[tcrq_pkg::MS_W-tcrq_pkg::DIV_RADIX_BITS-1:0], qbits};
      step <= step + 1'b1;
    end
  end

endmodule

FILE: rtl/core/tcrq_fifo.sv
module tcrq_fifo #(
  parameter int unsigned DEPTH = tcrq_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcrq_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output tcrq_pkg::cmd_t head,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tcrq_pkg::cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10: fill <= fill + 1'b1;
        2'b01: fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/core/tcrq_back.sv
module tcrq_back #(
  parameter int unsigned QUEUE_DEPTH = tcrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tcrq_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  tcrq_out_if.source     rsp
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Sorted store: each entry is a cell that compares against the new time
  logic [tcrq_pkg::KEY_W-1:0] st_key [QUEUE_DEPTH];
  logic [tcrq_pkg::VAL_W-1:0] st_val [QUEUE_DEPTH];
  logic [tcrq_pkg::MS_W-1:0] st_due [QUEUE_DEPTH];
  logic [CNT_W-1:0] count;
  logic [QUEUE_DEPTH-1:0] gt;

  tcrq_pkg::back_state_t state, state_next;
  logic [tcrq_pkg::MS_W-1:0] now;
  logic [tcrq_pkg::RES_CNT_W-1:0] n_rel;

  logic out_free;
  logic store_full;
  logic head_ok;
  logic next_ok;
  logic do_insert;
  logic do_release;
  logic do_emit;
  logic load_tick;
  logic emit_status;
  logic emit_last;
  logic [tcrq_pkg::KEY_W-1:0] emit_key;
  logic [tcrq_pkg::VAL_W-1:0] emit_val;
  logic [1:0] hund;
  logic [6:0] rest;
  logic [14:0] tens_prod;
  logic [3:0] tens;
  logic [3:0] ones;

  assign out_free = !rsp.valid || rsp.ready;
  assign store_full = (count >= CNT_W'(QUEUE_DEPTH));

  // Entries at or past the fill level count as later than anything
  always_comb begin
    for (int i = 0; i < int'(QUEUE_DEPTH); i++) begin
      gt[i] = (CNT_W'(i) >= count) || (st_due[i] > head.time_ms);
    end
  end

  assign head_ok = (count != '0) && (st_due[0] <= now) &&
                   (n_rel < tcrq_pkg::RES_CNT_W'(tcrq_pkg::MAX_RESULTS));
  assign next_ok = (count > CNT_W'(1)) && (st_due[1] <= now) &&
                   (n_rel < tcrq_pkg::RES_CNT_W'(tcrq_pkg::MAX_RESULTS - 1));

  always_comb begin
    state_next = state;
    pop = 1'b0;
    do_insert = 1'b0;
    do_release = 1'b0;
    do_emit = 1'b0;
    load_tick = 1'b0;
    emit_status = tcrq_pkg::STATUS_RELEASED;
    emit_last = 1'b1;
    emit_key = head.key;
    emit_val = head.value;
    case (state)
      tcrq_pkg::BS_IDLE: begin
        if (!empty) begin
          if (head.tick == tcrq_pkg::ACT_TICK) begin
            pop = 1'b1;
            load_tick = 1'b1;
            state_next = tcrq_pkg::BS_RELEASE;
          end else if (head.time_ms == '0) begin
            if (out_free) begin
              pop = 1'b1;
              do_emit = 1'b1;
            end
          end else if (store_full) begin
            emit_status = tcrq_pkg::STATUS_DROPPED;
            if (out_free) begin
              pop = 1'b1;
              do_emit = 1'b1;
            end
          end else begin
            pop = 1'b1;
            do_insert = 1'b1;
          end
        end
      end
      tcrq_pkg::BS_RELEASE: begin
        emit_key = st_key[0];
        emit_val = st_val[0];
        emit_last = !next_ok;
        if (!head_ok) begin
          state_next = tcrq_pkg::BS_IDLE;
        end else if (out_free) begin
          do_emit = 1'b1;
          do_release = 1'b1;
          if (!next_ok) begin
            state_next = tcrq_pkg::BS_IDLE;
          end
        end
      end
      default: begin
        state_next = tcrq_pkg::BS_IDLE;
      end
    endcase
  end

  // Decimal digits of the value byte
  always_comb begin
    if (emit_val >= 8'd200) begin
      hund = 2'd2;
    end else if (emit_val >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rest = 7'(emit_val - 8'(hund) * 8'd100);
    tens_prod = 15'(rest) * 15'd205;
    tens = tens_prod[14:11];
    ones = 4'(rest - 7'(tens) * 7'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcrq_pkg::BS_IDLE;
      count <= '0;
      n_rel <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_insert) begin
        count <= count + 1'b1;
      end else if (do_release) begin
        count <= count - 1'b1;
      end
      if (load_tick) begin
        n_rel <= '0;
      end else if (do_release) begin
        n_rel <= n_rel + 1'b1;
      end
      if (do_emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_tick) begin
      now <= head.time_ms;
    end
    if (do_emit) begin
      rsp.status <= emit_status;
      rsp.out_key <= emit_key;
      rsp.out_value <= emit_val;
      rsp.code_letter <= (emit_key >= tcrq_pkg::KEY_LAST_LETTER) ? tcrq_pkg::CHAR_Z :
                         tcrq_pkg::CHAR_A + tcrq_pkg::LETTER_W'(emit_key);
      rsp.digit_hundreds <= tcrq_pkg::CHAR_0 + tcrq_pkg::DIGIT_W'(hund);
      rsp.digit_tens <= tcrq_pkg::CHAR_0 + tcrq_pkg::DIGIT_W'(tens);
      rsp.digit_ones <= tcrq_pkg::CHAR_0 + tcrq_pkg::DIGIT_W'(ones);
      rsp.last <= emit_last;
    end
  end

  // Store update: insert opens a slot after equal times; release shifts down
  always_ff @(posedge clk) begin
    if (do_insert) begin
      if (gt[0]) begin
        st_key[0] <= head.key;
        st_val[0] <= head.value;
        st_due[0] <= head.time_ms;
      end
      for (int i = 1; i < int'(QUEUE_DEPTH); i++) begin
        if (gt[i]) begin
          if (gt[i-1]) begin
            st_key[i] <= st_key[i-1];
            st_val[i] <= st_val[i-1];
            st_due[i] <= st_due[i-1];
          end else begin
            st_key[i] <= head.key;
            st_val[i] <= head.value;
            st_due[i] <= head.time_ms;
          end
        end
      end
    end else if (do_release) begin
      for (int i = 0; i < int'(QUEUE_DEPTH) - 1; i++) begin
        st_key[i] <= st_key[i+1];
        st_val[i] <= st_val[i+1];
        st_due[i] <= st_due[i+1];
      end
    end
  end

endmodule

FILE: rtl/core/timed_command_release_queue.sv
// Path: an insert reaches the output register through the command queue;
// a tick first runs the 11-step radix-16 divider, then releases.
// Throughput: inserts 1 per cycle into the queue while it has room; the front takes
// nothing while a tick divides; releases, one store entry each, 1 per cycle unless rsp stalls.
// Reset: synchronous, active high; empties the store, the queue and the output.
module timed_command_release_queue #(
  parameter int unsigned QUEUE_DEPTH = tcrq_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tcrq_in_if.sink    req,
  tcrq_out_if.source rsp
);

  // Front: accept each transaction, classify it as insert or tick, and round
  // the tick's elapsed microseconds to milliseconds (half up) before handing
  // it on. Inserts pass straight through.
  tcrq_pkg::cmd_t push_data;
  logic push_valid;
  logic push_full;

  // Queue: decouple the divider from the store so either side can stall.
  tcrq_pkg::cmd_t head;
  logic empty;
  logic pop;

  tcrq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_full  (push_full)
  );

  tcrq_fifo #(
    .DEPTH (tcrq_pkg::FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .full      (push_full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // Back: hold the sorted store. Immediate and dropped inserts are reported
  // at once; queued inserts land in their sorted slot; a tick drains due entries
  // from the head, one per cycle unless the output stalls, marking the last of the run.
  tcrq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

FILE: test/timed_command_release_queue_tb.sv
module timed_command_release_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcrq_pkg::*;

  localparam int unsigned STORE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 460;
  // The last stretch of the run is driven flat out on both sides
  localparam int TAIL_ITEMS = 50;
  // The receiver's long hold-off starts once this many commands have gone in
  localparam int HOLD_AT_ITEM = 140;
  localparam int LONG_HOLD_CYCLES = 300;
  // Room for a tick to reach its first release, with ample margin
  localparam int SETTLE_CYCLES = 40;
  // Well above the long hold-off, the only long quiet spell of a good run
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [US_W-1:0] US_MAX = '1;
  localparam logic [MS_W-1:0] MS_MAX = '1;

  // One command as offered on the request channel, plus pacing marks
  typedef struct {
    logic action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [MS_W-1:0] due;
    logic [US_W-1:0] us;
    bit drain_first;
    bit calm;
  } command_t;

  // One entry of the time-sorted store
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [MS_W-1:0] due;
  } stored_cmd_t;

  // One release (or drop report) as it should leave the block
  typedef struct {
    logic status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [LETTER_W-1:0] letter;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
    logic last;
  } release_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcrq_in_if cmd_if ();
  tcrq_out_if rel_if ();

  timed_command_release_queue #(
    .QUEUE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(cmd_if),
    .rsp(rel_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Commands still to be offered, the predicted store and the releases owed
  command_t cmd_backlog[$];
  stored_cmd_t stored_cmds[$];
  release_t awaited_releases[$];

  int items_total = 0;
  int items_accepted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  logic in_fired = 1'b0;
  logic tail_phase = 1'b0;

  // Sender pacing
  logic offering = 1'b0;
  int send_gap = 0;
  int send_calm = 0;

  // Receiver pacing
  int stall_left = 0;
  int rx_calm = 0;
  bit long_hold_done = 1'b0;

  // Running wall clock used to give the random commands sensible due times
  longint unsigned clock_us;

  function automatic logic [MS_W-1:0] clock_ms();
    return MS_W'(clock_us / US_PER_MS);
  endfunction

  // Build the ASCII code of a command: letter from the key, three digits
  function automatic release_t encode_release(input logic status,
                                              input logic [KEY_W-1:0] key,
                                              input logic [VAL_W-1:0] value);
    release_t r;
    r.status = status;
    r.key = key;
    r.value = value;
    // Every key from the last letter upwards shares the letter Z
    r.letter = (key >= KEY_LAST_LETTER) ? CHAR_Z : LETTER_W'(CHAR_A + key);
    r.hundreds = DIGIT_W'(CHAR_0 + value / 100);
    r.tens = DIGIT_W'(CHAR_0 + (value / 10) % 10);
    r.ones = DIGIT_W'(CHAR_0 + value % 10);
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the predicted store by one accepted command and queue the
  // releases it owes
  task automatic predict_command(input command_t c);
    release_t r;
    stored_cmd_t s;
    logic [US_W-1:0] now_ms;
    int pos;
    int n;
    n = 0;
    if (c.action == ACT_INSERT) begin
      if (c.due == '0) begin
        // Zero due time: out at once, store untouched
        r = encode_release(STATUS_RELEASED, c.key, c.value);
        r.last = 1'b1;
        awaited_releases.push_back(r);
      end else if (stored_cmds.size() >= STORE_DEPTH) begin
        // Store full: drop and report it
        r = encode_release(STATUS_DROPPED, c.key, c.value);
        r.last = 1'b1;
        awaited_releases.push_back(r);
      end else begin
        // Place after every entry with an equal or earlier due time
        pos = 0;
        while (pos < stored_cmds.size() && stored_cmds[pos].due <= c.due)
          pos++;
        s.key = c.key;
        s.value = c.value;
        s.due = c.due;
        stored_cmds.insert(pos, s);
      end
    end else begin
      // Round microseconds to milliseconds, half up on the hundreds digit
      now_ms = c.us / US_PER_MS;
      if ((c.us / 100) % 10 > 4)
        now_ms = now_ms + 1;
      while (stored_cmds.size() > 0 && n < MAX_RESULTS &&
             US_W'(stored_cmds[0].due) <= now_ms) begin
        r = encode_release(STATUS_RELEASED, stored_cmds[0].key, stored_cmds[0].value);
        awaited_releases.push_back(r);
        void'(stored_cmds.pop_front());
        n++;
      end
      // Mark the final release of this tick
      if (n > 0) begin
        r = awaited_releases.pop_back();
        r.last = 1'b1;
        awaited_releases.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus builders; fields a command does not use carry random filler
  task automatic queue_insert(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value,
                              input logic [MS_W-1:0] due, input bit drain);
    command_t c;
    c.action = ACT_INSERT;
    c.key = key;
    c.value = value;
    c.due = due;
    c.us = US_W'({$urandom(), $urandom()});
    c.drain_first = drain;
    c.calm = 1'b0;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_tick(input logic [US_W-1:0] us, input bit drain);
    command_t c;
    c.action = ACT_TICK;
    c.key = KEY_W'($urandom());
    c.value = VAL_W'($urandom());
    c.due = MS_W'($urandom());
    c.us = us;
    c.drain_first = drain;
    c.calm = 1'b0;
    cmd_backlog.push_back(c);
  endtask

  // Empty the store with a far-future tick, fill it to the brim, then push
  // a few more inserts that must be dropped. Dropped inserts are the only
  // place where due times beyond any reachable tick are used, so no entry
  // can stick in the store for good.
  task automatic overflow_store(input bit extremes);
    logic [MS_W-1:0] base;
    logic [MS_W-1:0] due;
    if (extremes)
      queue_tick(US_MAX, 1'b1);
    else
      queue_tick({1'b1, 39'({$urandom(), $urandom()})}, 1'b1);
    base = clock_ms();
    repeat (STORE_DEPTH)
      queue_insert(KEY_W'($urandom_range(0, 31)), VAL_W'($urandom_range(0, 255)),
                   base + MS_W'($urandom_range(1, 40)), 1'b0);
    if (extremes) begin
      queue_insert(KEY_LAST_LETTER, '1, MS_MAX, 1'b0);
      queue_insert('0, '0, MS_W'(1), 1'b0);
    end
    repeat ($urandom_range(1, 4)) begin
      due = MS_W'($urandom());
      if (due == '0)
        due = MS_MAX;
      queue_insert(KEY_W'($urandom_range(0, 31)), VAL_W'($urandom_range(0, 255)), due, 1'b0);
    end
  endtask

  // Monitor: sample both channels at the rising edge, predict accepted
  // commands and check every release against the oldest one owed
  always @(posedge clk) begin : watch_channels
    command_t seen;
    release_t got;
    release_t want;
    logic take_in;
    logic take_out;
    take_in = !rst && cmd_if.valid && cmd_if.ready;
    take_out = !rst && rel_if.valid && rel_if.ready;
    in_fired <= take_in;
    quiet_cycles <= (take_in || take_out) ? 0 : quiet_cycles + 1;
    if (take_in) begin
      seen.action = cmd_if.action;
      seen.key = cmd_if.cmd_key;
      seen.value = cmd_if.cmd_value;
      seen.due = cmd_if.due_ms;
      seen.us = cmd_if.elapsed_us;
      seen.drain_first = 1'b0;
      seen.calm = 1'b0;
      predict_command(seen);
      items_accepted <= items_accepted + 1;
    end
    if (take_out) begin
      got.status = rel_if.status;
      got.key = rel_if.out_key;
      got.value = rel_if.out_value;
      got.letter = rel_if.code_letter;
      got.hundreds = rel_if.digit_hundreds;
      got.tens = rel_if.digit_tens;
      got.ones = rel_if.digit_ones;
      got.last = rel_if.last;
      if (awaited_releases.size() == 0) begin
        $error("release transaction with none owed: key %0d value %0d", got.key, got.value);
        mismatches++;
      end else begin
        want = awaited_releases.pop_front();
        check_field("status", want.status, got.status);
        check_field("out_key", want.key, got.key);
        check_field("out_value", want.value, got.value);
        check_field("code_letter", want.letter, got.letter);
        check_field("digit_hundreds", want.hundreds, got.hundreds);
        check_field("digit_tens", want.tens, got.tens);
        check_field("digit_ones", want.ones, got.ones);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Driver: change the request channel on the falling edge only. Drop valid
  // for a random burst after some transactions, and hold back a command
  // marked drain-first until every owed release has come out.
  always @(negedge clk) begin : drive_commands
    command_t nxt;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (in_fired) begin
        offering = 1'b0;
        if (!tail_phase && send_calm == 0 && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 12);
      end
      // Now and then run a stretch with no gaps at all
      if (send_calm > 0)
        send_calm--;
      else if ($urandom_range(0, 39) == 0)
        send_calm = $urandom_range(20, 60);
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].drain_first && awaited_releases.size() != 0)) begin
          nxt = cmd_backlog.pop_front();
          offering = 1'b1;
          cmd_if.action <= nxt.action;
          cmd_if.cmd_key <= nxt.key;
          cmd_if.cmd_value <= nxt.value;
          cmd_if.due_ms <= nxt.due;
          cmd_if.elapsed_us <= nxt.us;
          tail_phase <= nxt.calm;
        end
      end
      cmd_if.valid <= offering;
    end
  end

  // Receiver: stall in random bursts, plus one long hold-off while the
  // sender keeps pushing, so the block backs up and stalls its input
  always @(negedge clk) begin : pace_releases
    if (rst) begin
      rel_if.ready <= 1'b0;
    end else begin
      if (!long_hold_done && items_accepted >= HOLD_AT_ITEM) begin
        stall_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else if (stall_left == 0 && !tail_phase && rx_calm == 0 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (rx_calm > 0)
        rx_calm--;
      else if ($urandom_range(0, 39) == 0)
        rx_calm = $urandom_range(20, 60);
      if (stall_left > 0) begin
        stall_left--;
        rel_if.ready <= 1'b0;
      end else begin
        rel_if.ready <= 1'b1;
      end
    end
  end

  initial begin : run_test
    logic [MS_W-1:0] due;
    int target;
    int i;
    bit burst_added;
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_INSERT;
    cmd_if.cmd_key = '0;
    cmd_if.cmd_value = '0;
    cmd_if.due_ms = '0;
    cmd_if.elapsed_us = '0;
    rel_if.ready = 1'b0;
    burst_added = 1'b0;

    // Immediate releases at the extremes of key and value, including a key
    // above the last letter
    queue_insert('0, '0, '0, 1'b0);
    queue_insert(KEY_LAST_LETTER, '1, '0, 1'b0);
    queue_insert('1, VAL_W'(100), '0, 1'b0);
    queue_insert(KEY_W'(18), VAL_W'(209), '0, 1'b0);
    // Tick on an empty store: nothing out
    queue_tick('0, 1'b0);
    // Equal due times keep arrival order; 1499 us rounds down, 1500 up
    queue_insert(KEY_W'(5), VAL_W'(10), MS_W'(2), 1'b0);
    queue_insert(KEY_W'(6), VAL_W'(20), MS_W'(1), 1'b0);
    queue_insert(KEY_W'(7), VAL_W'(30), MS_W'(1), 1'b0);
    queue_insert(KEY_W'(8), VAL_W'(40), MS_W'(2), 1'b0);
    queue_tick(US_W'(1499), 1'b0);
    queue_tick(US_W'(1500), 1'b0);
    // Queued insert with nothing due yet, then due exactly on the half
    queue_insert(KEY_W'(1), VAL_W'(1), MS_W'(3), 1'b0);
    queue_tick(US_W'(2499), 1'b0);
    queue_tick(US_W'(2500), 1'b0);
    queue_tick(US_MAX, 1'b0);

    // Random part: open with a full store and drops at the due-time extremes
    target = cmd_backlog.size() + RANDOM_ITEMS;
    clock_us = 64'd20_000_000 + $urandom_range(0, 999);
    overflow_store(1'b1);
    while (cmd_backlog.size() < target) begin
      // Flood of immediate inserts lined up with the receiver's long hold-off
      if (!burst_added && cmd_backlog.size() >= HOLD_AT_ITEM - 10) begin
        burst_added = 1'b1;
        repeat (24)
          queue_insert(KEY_W'($urandom_range(0, 31)), VAL_W'($urandom_range(0, 255)),
                       '0, 1'b0);
      end
      case ($urandom_range(0, 19))
        0: overflow_store(1'b0);
        1, 2: begin
          // Many commands falling due on the same tick
          due = clock_ms() + MS_W'($urandom_range(1, 5));
          repeat ($urandom_range(2, 16))
            queue_insert(KEY_W'($urandom_range(0, 31)), VAL_W'($urandom_range(0, 255)),
                         due, 1'b0);
          clock_us += 6000 + $urandom_range(0, 999);
          queue_tick(US_W'(clock_us), 1'b0);
        end
        3, 4: begin
          // Noise: ticks at any time, immediate inserts of any key
          repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 1) == 0)
              queue_tick(($urandom_range(0, 3) == 0) ? US_W'($urandom_range(0, 99999))
                                                     : US_W'({$urandom(), $urandom()}),
                         1'b0);
            else
              queue_insert(KEY_W'($urandom()), VAL_W'($urandom()), '0, 1'b0);
          end
        end
        default: begin
          // Ordinary timeline: commands due a little ahead, time moving on
          repeat ($urandom_range(4, 12)) begin
            case ($urandom_range(0, 9))
              0, 1:
                queue_insert(KEY_W'($urandom_range(0, 31)), VAL_W'($urandom_range(0, 255)),
                             '0, 1'b0);
              2, 3, 4, 5:
                queue_insert(KEY_W'($urandom_range(0, 31)), VAL_W'($urandom_range(0, 255)),
                             clock_ms() + MS_W'($urandom_range(0, 30)), 1'b0);
              default: begin
                clock_us += $urandom_range(200, 4000);
                queue_tick(US_W'(clock_us), $urandom_range(0, 24) == 0);
              end
            endcase
          end
        end
      endcase
    end
    for (i = cmd_backlog.size() - TAIL_ITEMS; i < cmd_backlog.size(); i++)
      cmd_backlog[i].calm = 1'b1;
    items_total = cmd_backlog.size();

    // Hold reset, then release it just after a rising edge
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to go in and every owed release to come out
    while ((items_accepted < items_total || awaited_releases.size() != 0) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(negedge clk);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d releases owed", quiet_cycles,
             awaited_releases.size());
      $display("Some tests failed");
    end else begin
      // Catch any stray release that follows the last owed one
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (mismatches == 0)
        $display("All tests passed");
      else
        $display("Some tests failed");
    end
    $finish;
  end

endmodule
